### rtl/core/tcm_pkg.sv
package tcm_pkg;

  // default fraction width of the fixed-point format
  localparam int FRAC_BITS_DEF = 14;

  // command kinds; any other code stops all thrusters
  typedef enum logic [1:0] {
    KIND_MOVE = 2'd0,
    KIND_YAW  = 2'd1,
    KIND_KILL = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_STRAFE_RATIO  = 3'd0,
    REG_REVERSE_RATIO = 3'd1,
    REG_MAX_POWER     = 3'd2,
    REG_FORWARD_TRIMS = 3'd3,
    REG_DIVE_TRIMS    = 3'd4,
    REG_DIVE_OFFSETS  = 3'd5
  } reg_idx_t;

  // reset values of the configuration registers
  localparam logic [14:0] STRAFE_RATIO_RST  = 15'd16384;
  localparam logic [14:0] REVERSE_RATIO_RST = 15'd16384;
  localparam logic [14:0] MAX_POWER_RST     = 15'd16384;
  localparam logic [31:0] FORWARD_TRIMS_RST = 32'h4000_4000;
  localparam logic [31:0] DIVE_TRIMS_RST    = 32'h4000_4000;
  localparam logic [31:0] DIVE_OFFSETS_RST  = 32'h0000_0000;

endpackage

### rtl/core/thruster_command_mixer.sv
// channel | handshake             | payload
// --------+-----------------------+------------------------------------------
// cfg     | cfg_we                | cfg_index[2:0], cfg_data[31:0]
// in      | in_valid / in_stall   | in_kind, in_forward, in_strafe, in_dive,
//         |                       | in_yaw
// out     | out_valid / out_stall | six signed drives
//
// One command per cycle is taken while in_stall is low. Pipeline depth grows
// with FRAC_BITS through the restoring divider for the power scale,
// which resolves one quotient bit per pipeline stage.
// rst_n is synchronous; it clears valid bits and loads register defaults.
// An output register plus one skid entry decouple the channels: in_stall
// rises only once the skid entry holds an item behind a stalled result.
module thruster_command_mixer #(
  parameter int FRAC_BITS = tcm_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_forward,
  input  logic signed [15:0] in_strafe,
  input  logic signed [15:0] in_dive,
  input  logic signed [15:0] in_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_forward_drive,
  output logic signed [15:0] out_right_forward_drive,
  output logic signed [15:0] out_left_strafe_drive,
  output logic signed [15:0] out_right_strafe_drive,
  output logic signed [15:0] out_front_dive_drive,
  output logic signed [15:0] out_rear_dive_drive
);
  import tcm_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int S_W  = 33 - F;
  localparam int DW   = (48 - 2 * F > 18) ? 48 - 2 * F : 18;
  localparam int SCW  = F + 1;
  localparam int DVW  = (F + 2 > 18) ? F + 2 : 18;
  localparam int MULX = (SCW + 1 > 16) ? SCW + 1 : 16;
  localparam int PMAX = DW + MULX + 1;
  localparam int TW   = DW + 17;
  localparam int DTW  = DVW + 17;
  localparam int NS   = 7 + F;

  localparam logic [PMAX-1:0]       HALF    = PMAX'(1) << (F - 1);
  localparam logic [SCW-1:0]        ONE_SC  = SCW'(1) << F;
  localparam logic signed [DVW-1:0] ONE_DV  = DVW'(1) << F;

  typedef struct packed {
    logic signed [DW-1:0] fl;
    logic signed [DW-1:0] fr;
    logic signed [15:0]   str;
    logic signed [15:0]   dv;
    logic [1:0]           kind;
    logic                 need;
    logic [DW-1:0]        mag;
  } carry_t;

  typedef struct packed {
    logic signed [15:0] lf;
    logic signed [15:0] rf;
    logic signed [15:0] ls;
    logic signed [15:0] rs;
    logic signed [15:0] fd;
    logic signed [15:0] rd;
  } drive_t;

  // product rounded to nearest, ties away from zero
  function automatic logic signed [PMAX-1:0] rnd(input logic signed [PMAX-1:0] p);
    logic [PMAX-1:0] u;
    u = p[PMAX-1] ? PMAX'(-p) : p;
    u = (u + HALF) >> F;
    rnd = p[PMAX-1] ? -$signed(u) : $signed(u);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PMAX-1:0] p);
    if (p > $signed(PMAX'(32767))) sat16 = 16'sh7FFF;
    else if (p < -$signed(PMAX'(32768))) sat16 = 16'sh8000;
    else sat16 = p[15:0];
  endfunction

  // configuration registers
  logic [14:0] strafe_ratio_r, reverse_ratio_r, max_power_r;
  logic [31:0] forward_trims_r, dive_trims_r, dive_offsets_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strafe_ratio_r  <= STRAFE_RATIO_RST;
      reverse_ratio_r <= REVERSE_RATIO_RST;
      max_power_r     <= MAX_POWER_RST;
      forward_trims_r <= FORWARD_TRIMS_RST;
      dive_trims_r    <= DIVE_TRIMS_RST;
      dive_offsets_r  <= DIVE_OFFSETS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STRAFE_RATIO:  strafe_ratio_r  <= cfg_data[14:0];
        REG_REVERSE_RATIO: reverse_ratio_r <= cfg_data[14:0];
        REG_MAX_POWER:     max_power_r     <= cfg_data[14:0];
        REG_FORWARD_TRIMS: forward_trims_r <= cfg_data;
        REG_DIVE_TRIMS:    dive_trims_r    <= cfg_data;
        REG_DIVE_OFFSETS:  dive_offsets_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] rev_s;
  assign rev_s = $signed({1'b0, reverse_ratio_r});

  // pipeline enable and valid bits
  logic          en;
  logic [NS-1:0] v_r;
  logic          out_valid_r, skid_v_r;
  drive_t        out_r, skid_r, res;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // stage 1: strafe gain and yaw reverse-side product
  logic signed [S_W-1:0] s1_s_r;
  logic signed [DW-1:0]  s1_yq_r;
  logic signed [15:0]    s1_fwd_r, s1_str_r, s1_dv_r, s1_yw_r;
  logic [1:0]            s1_kind_r;
  logic signed [31:0]    s1_sp;
  logic [16:0]           s1_yabs;
  logic signed [33:0]    s1_yp;

  always_comb begin
    s1_sp   = in_strafe * $signed({1'b0, strafe_ratio_r});
    s1_yabs = in_yaw[15] ? 17'(-$signed({in_yaw[15], in_yaw})) : {1'b0, in_yaw};
    s1_yp   = $signed({1'b0, s1_yabs}) * rev_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_s_r    <= S_W'(rnd(PMAX'(s1_sp)));
      s1_yq_r   <= DW'(rnd(PMAX'(s1_yp)));
      s1_fwd_r  <= in_forward;
      s1_str_r  <= in_strafe;
      s1_dv_r   <= in_dive;
      s1_yw_r   <= in_yaw;
      s1_kind_r <= in_kind;
    end
  end

  // stage 2: reverse-side product of the strafe pair, yaw pair
  logic signed [DW-1:0]  s2_q_r, s2_yl_r, s2_yr_r;
  logic signed [S_W-1:0] s2_s_r;
  logic signed [15:0]    s2_fwd_r, s2_str_r, s2_dv_r;
  logic [1:0]            s2_kind_r;
  logic [S_W-1:0]        s2_sabs;
  logic signed [S_W+16:0] s2_qp;

  always_comb begin
    s2_sabs = s1_s_r[S_W-1] ? S_W'(-s1_s_r) : s1_s_r;
    s2_qp   = $signed({1'b0, s2_sabs}) * rev_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q_r    <= DW'(rnd(PMAX'(s2_qp)));
      s2_s_r    <= s1_s_r;
      s2_yl_r   <= s1_yw_r[15] ? DW'(s1_yw_r) : s1_yq_r;
      s2_yr_r   <= s1_yw_r[15] ? s1_yq_r : -DW'(s1_yw_r);
      s2_fwd_r  <= s1_fwd_r;
      s2_str_r  <= s1_str_r;
      s2_dv_r   <= s1_dv_r;
      s2_kind_r <= s1_kind_r;
    end
  end

  // stage 3: add forward, or take the yaw pair
  logic signed [DW-1:0] s3_fl_r, s3_fr_r, s3_cl, s3_cr;
  logic signed [15:0]   s3_str_r, s3_dv_r;
  logic [1:0]           s3_kind_r;

  always_comb begin
    s3_cl = s2_s_r[S_W-1] ? DW'(s2_s_r) : s2_q_r;
    s3_cr = s2_s_r[S_W-1] ? s2_q_r : -DW'(s2_s_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_kind_r == KIND_MOVE) begin
        s3_fl_r <= s3_cl + DW'(s2_fwd_r);
        s3_fr_r <= s3_cr + DW'(s2_fwd_r);
      end else begin
        s3_fl_r <= s2_yl_r;
        s3_fr_r <= s2_yr_r;
      end
      s3_str_r  <= s2_str_r;
      s3_dv_r   <= s2_dv_r;
      s3_kind_r <= s2_kind_r;
    end
  end

  // stage 4: larger magnitude and limit check
  carry_t        s4_c_r;
  logic [DW-1:0] s4_al, s4_ar, s4_mag;

  always_comb begin
    s4_al  = s3_fl_r[DW-1] ? DW'(-s3_fl_r) : s3_fl_r;
    s4_ar  = s3_fr_r[DW-1] ? DW'(-s3_fr_r) : s3_fr_r;
    s4_mag = (s4_al > s4_ar) ? s4_al : s4_ar;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_c_r.fl   <= s3_fl_r;
      s4_c_r.fr   <= s3_fr_r;
      s4_c_r.str  <= s3_str_r;
      s4_c_r.dv   <= s3_dv_r;
      s4_c_r.kind <= s3_kind_r;
      s4_c_r.mag  <= s4_mag;
      s4_c_r.need <= (s3_kind_r == KIND_MOVE) && (s4_mag > DW'(max_power_r));
    end
  end

  // restoring divider: max_power << F / mag, one quotient bit per stage
  carry_t        div_c_r   [F];
  logic [DW:0]   div_rem_r [F];
  logic [F-1:0]  div_q_r   [F];
  carry_t        div_c_in  [F];
  logic [DW:0]   div_rem_nxt [F];
  logic [F-1:0]  div_q_nxt [F];

  always_comb begin
    for (int j = 0; j < F; j++) begin
      logic [DW:0]  t;
      logic [F-1:0] qi;
      if (j == 0) begin
        div_c_in[j] = s4_c_r;
        t  = {DW'(max_power_r), 1'b0};
        qi = '0;
      end else begin
        div_c_in[j] = div_c_r[j-1];
        t  = {div_rem_r[j-1][DW-1:0], 1'b0};
        qi = div_q_r[j-1];
      end
      if (t >= {1'b0, div_c_in[j].mag}) begin
        div_rem_nxt[j] = t - {1'b0, div_c_in[j].mag};
        div_q_nxt[j]   = {qi[F-2:0], 1'b1};
      end else begin
        div_rem_nxt[j] = t;
        div_q_nxt[j]   = {qi[F-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < F; j++) begin
        div_c_r[j]   <= div_c_in[j];
        div_rem_r[j] <= div_rem_nxt[j];
        div_q_r[j]   <= div_q_nxt[j];
      end
    end
  end

  // stage 5: apply scale to the forward pair, strafe and dive
  carry_t               s5_c;
  logic [SCW-1:0]       s5_scale;
  logic signed [SCW:0]  s5_sc;
  logic signed [DW+SCW:0] s5_pl, s5_pr;
  logic signed [SCW+16:0] s5_ps, s5_pd;
  logic signed [DW-1:0] s5_fl_r, s5_fr_r;
  logic signed [16:0]   s5_ss_r, s5_sd_r;
  logic [1:0]           s5_kind_r;

  always_comb begin
    s5_c     = div_c_r[F-1];
    s5_scale = s5_c.need ? {1'b0, div_q_r[F-1]} : ONE_SC;
    s5_sc    = $signed({1'b0, s5_scale});
    s5_pl    = s5_c.fl * s5_sc;
    s5_pr    = s5_c.fr * s5_sc;
    s5_ps    = s5_c.str * s5_sc;
    s5_pd    = s5_c.dv * s5_sc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_fl_r   <= DW'(rnd(PMAX'(s5_pl)));
      s5_fr_r   <= DW'(rnd(PMAX'(s5_pr)));
      s5_ss_r   <= 17'(rnd(PMAX'(s5_ps)));
      s5_sd_r   <= 17'(rnd(PMAX'(s5_pd)));
      s5_kind_r <= s5_c.kind;
    end
  end

  // stage 6: strafe reverse-side product, dive offsets and clamp
  logic [16:0]           s6_sabs;
  logic signed [33:0]    s6_qp;
  logic signed [DVW-1:0] s6_sf, s6_sr;
  logic signed [DW-1:0]  s6_fl_r, s6_fr_r, s6_q_r;
  logic signed [16:0]    s6_ss_r;
  logic signed [DVW-1:0] s6_df_r, s6_dr_r;
  logic [1:0]            s6_kind_r;

  always_comb begin
    s6_sabs = s5_ss_r[16] ? 17'(-s5_ss_r) : s5_ss_r;
    s6_qp   = $signed({1'b0, s6_sabs}) * rev_s;
    s6_sf   = DVW'(s5_sd_r) + DVW'($signed(dive_offsets_r[15:0]));
    s6_sr   = DVW'(s5_sd_r) + DVW'($signed(dive_offsets_r[31:16]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q_r  <= DW'(rnd(PMAX'(s6_qp)));
      s6_df_r <= (s6_sf > ONE_DV) ? ONE_DV : ((s6_sf < -ONE_DV) ? -ONE_DV : s6_sf);
      s6_dr_r <= (s6_sr > ONE_DV) ? ONE_DV : ((s6_sr < -ONE_DV) ? -ONE_DV : s6_sr);
      s6_fl_r   <= s5_fl_r;
      s6_fr_r   <= s5_fr_r;
      s6_ss_r   <= s5_ss_r;
      s6_kind_r <= s5_kind_r;
    end
  end

  // stage 7: trims and strafe pair
  logic signed [DW+15:0]  s7_pl, s7_pr;
  logic signed [DVW+15:0] s7_pf, s7_pb;
  logic signed [TW-1:0]   s7_fl_r, s7_fr_r;
  logic signed [DTW-1:0]  s7_df_r, s7_dr_r;
  logic signed [DW-1:0]   s7_sl_r, s7_sr_r;
  logic [1:0]             s7_kind_r;

  always_comb begin
    s7_pl = s6_fl_r * $signed(forward_trims_r[15:0]);
    s7_pr = s6_fr_r * $signed(forward_trims_r[31:16]);
    s7_pf = s6_df_r * $signed(dive_trims_r[15:0]);
    s7_pb = s6_dr_r * $signed(dive_trims_r[31:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_fl_r <= TW'(rnd(PMAX'(s7_pl)));
      s7_fr_r <= TW'(rnd(PMAX'(s7_pr)));
      s7_df_r <= DTW'(rnd(PMAX'(s7_pf)));
      s7_dr_r <= DTW'(rnd(PMAX'(s7_pb)));
      if (s6_kind_r != KIND_MOVE) begin
        s7_sl_r <= '0;
        s7_sr_r <= '0;
      end else if (s6_ss_r[16]) begin
        s7_sl_r <= DW'(s6_ss_r);
        s7_sr_r <= s6_q_r;
      end else begin
        s7_sl_r <= s6_q_r;
        s7_sr_r <= -DW'(s6_ss_r);
      end
      s7_kind_r <= s6_kind_r;
    end
  end

  // saturation; kill and unused kinds give zeros
  always_comb begin
    if (s7_kind_r == KIND_MOVE || s7_kind_r == KIND_YAW) begin
      res.lf = sat16(PMAX'(s7_fl_r));
      res.rf = sat16(PMAX'(s7_fr_r));
      res.ls = sat16(PMAX'(s7_sl_r));
      res.rs = sat16(PMAX'(s7_sr_r));
      res.fd = sat16(PMAX'(s7_df_r));
      res.rd = sat16(PMAX'(s7_dr_r));
    end else begin
      res = '0;
    end
  end

  // output register and skid entry
  logic take;
  assign take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_r <= v_r[NS-1];
    end else if (v_r[NS-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take) begin
      out_r <= res;
    end else begin
      skid_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_left_forward_drive  = out_r.lf;
  assign out_right_forward_drive = out_r.rf;
  assign out_left_strafe_drive   = out_r.ls;
  assign out_right_strafe_drive  = out_r.rs;
  assign out_front_dive_drive    = out_r.fd;
  assign out_rear_dive_drive     = out_r.rd;

endmodule

### verif/thruster_command_mixer_tb.sv
module thruster_command_mixer_tb;
  import tcm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = FB + 8;

  // one set of six drives
  typedef struct packed {
    logic signed [15:0] lf;
    logic signed [15:0] rf;
    logic signed [15:0] ls;
    logic signed [15:0] rs;
    logic signed [15:0] fd;
    logic signed [15:0] rd;
  } drives_t;

  // expected drives and mismatch bookkeeping
  class drive_scoreboard;
    drives_t pending[$];
    int unsigned errors;

    function void note_command(drives_t d);
      pending.push_back(d);
    endfunction

    function void check_drives(drives_t got);
      drives_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("drive mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic signed [15:0] in_forward = '0, in_strafe = '0, in_dive = '0, in_yaw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  drives_t got;

  thruster_command_mixer dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_forward(in_forward), .in_strafe(in_strafe),
    .in_dive(in_dive), .in_yaw(in_yaw),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_forward_drive(got.lf), .out_right_forward_drive(got.rf),
    .out_left_strafe_drive(got.ls), .out_right_strafe_drive(got.rs),
    .out_front_dive_drive(got.fd), .out_rear_dive_drive(got.rd)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  drive_scoreboard sb = new();

  // mixer settings as the block should hold them
  logic [14:0] m_strafe_ratio, m_reverse_ratio, m_max_power;
  logic [31:0] m_forward_trims, m_dive_trims, m_dive_offsets;

  // fixed-point product, rounded to nearest with ties away from zero
  function automatic longint qmul(longint a, longint b);
    longint p, u;
    p = a * b;
    u = (p < 0) ? -p : p;
    u = (u + (64'sd1 <<< (FB - 1))) >>> FB;
    return (p < 0) ? -u : u;
  endfunction

  function automatic void split_pair(longint v, output longint l, output longint r);
    if (v < 0) begin
      l = v;
      r = qmul(-v, m_reverse_ratio);
    end else begin
      l = qmul(v, m_reverse_ratio);
      r = -v;
    end
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = 64'sd1 <<< FB;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint s16(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // expected drives for one command
  function automatic drives_t mix_command(logic [1:0] kind, logic signed [15:0] fwd,
      logic signed [15:0] str, logic signed [15:0] dv, logic signed [15:0] yw);
    longint fl, fr, sl, sr, df, dr, cl, cr, mag, scale, sdive;
    drives_t d;
    fl = 0; fr = 0; sl = 0; sr = 0; df = 0; dr = 0;
    if (kind == KIND_MOVE || kind == KIND_YAW) begin
      if (kind == KIND_MOVE) begin
        scale = 64'sd1 <<< FB;
        split_pair(qmul(s16(str), m_strafe_ratio), cl, cr);
        fl = cl + s16(fwd);
        fr = cr + s16(fwd);
        mag = ((fl < 0) ? -fl : fl) > ((fr < 0) ? -fr : fr) ?
              ((fl < 0) ? -fl : fl) : ((fr < 0) ? -fr : fr);
        if (mag > longint'(m_max_power))
          scale = (longint'(m_max_power) <<< FB) / mag;
        fl = qmul(fl, scale);
        fr = qmul(fr, scale);
        split_pair(qmul(s16(str), scale), sl, sr);
        sdive = qmul(s16(dv), scale);
      end else begin
        split_pair(s16(yw), fl, fr);
        sdive = s16(dv);
      end
      df = clamp_unit(sdive + s16(m_dive_offsets[15:0]));
      dr = clamp_unit(sdive + s16(m_dive_offsets[31:16]));
      fl = qmul(fl, s16(m_forward_trims[15:0]));
      fr = qmul(fr, s16(m_forward_trims[31:16]));
      df = qmul(df, s16(m_dive_trims[15:0]));
      dr = qmul(dr, s16(m_dive_trims[31:16]));
    end
    d.lf = sat16(fl); d.rf = sat16(fr); d.ls = sat16(sl);
    d.rs = sat16(sr); d.fd = sat16(df); d.rd = sat16(dr);
    return d;
  endfunction

  // register write, only while idle
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_STRAFE_RATIO: m_strafe_ratio = value[14:0];
      REG_REVERSE_RATIO: m_reverse_ratio = value[14:0];
      REG_MAX_POWER: m_max_power = value[14:0];
      REG_FORWARD_TRIMS: m_forward_trims = value;
      REG_DIVE_TRIMS: m_dive_trims = value;
      REG_DIVE_OFFSETS: m_dive_offsets = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  bit idle_gaps = 1'b1;

  // one command transfer, with a random gap first while idle_gaps is set
  task automatic send_command(logic [1:0] kind, logic [15:0] fwd, logic [15:0] str,
      logic [15:0] dv, logic [15:0] yw);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_forward <= fwd; in_strafe <= str; in_dive <= dv; in_yaw <= yw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(mix_command(kind, fwd, str, dv, yw));
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 1) ? 16384 : -16384);
      3: return 16'($signed($urandom_range(0, 4096)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_trims();
    case ($urandom_range(0, 3))
      0: return 32'h4000_4000;
      1: return {16'($urandom_range(12000, 20000)), 16'($urandom_range(12000, 20000))};
      default: return $urandom;
    endcase
  endfunction

  // receiver: while stall_gaps is set, a random wait after each transfer
  bit stall_gaps = 1'b1;
  int rx_wait = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_drives(got);
      rx_wait = stall_gaps ? $urandom_range(0, 7) : 0;
    end
  end
  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    m_strafe_ratio = STRAFE_RATIO_RST; m_reverse_ratio = REVERSE_RATIO_RST;
    m_max_power = MAX_POWER_RST; m_forward_trims = FORWARD_TRIMS_RST;
    m_dive_trims = DIVE_TRIMS_RST; m_dive_offsets = DIVE_OFFSETS_RST;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, every kind, scaling, reverse pairs, clamps
    send_command(KIND_MOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(KIND_MOVE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_command(KIND_MOVE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_command(KIND_MOVE, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_command(KIND_MOVE, 16'h2000, 16'h1000, 16'hf000, 16'h1234);
    send_command(KIND_MOVE, 16'h1000, 16'hf000, 16'h4000, 16'h0000);
    send_command(KIND_YAW, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
    send_command(KIND_YAW, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
    send_command(KIND_YAW, 16'h1111, 16'h2222, 16'h3000, 16'hc000);
    send_command(KIND_KILL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_command(2'd3, 16'h8000, 16'h4000, 16'h4000, 16'h4000);
    drain();

    // extremes of the settings, then random settings
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_STRAFE_RATIO, 32'h0);
          write_reg(REG_REVERSE_RATIO, 32'h0);
          write_reg(REG_MAX_POWER, 32'h0);
          write_reg(REG_FORWARD_TRIMS, 32'h0);
          write_reg(REG_DIVE_TRIMS, 32'h0);
          write_reg(REG_DIVE_OFFSETS, 32'h0);
        end
        1: begin
          write_reg(REG_STRAFE_RATIO, 32'hffff_ffff);
          write_reg(REG_REVERSE_RATIO, 32'hffff_ffff);
          write_reg(REG_MAX_POWER, 32'h7fff);
          write_reg(REG_FORWARD_TRIMS, 32'h7fff_7fff);
          write_reg(REG_DIVE_TRIMS, 32'h8000_8000);
          write_reg(REG_DIVE_OFFSETS, 32'h7fff_8000);
        end
        2: begin
          write_reg(REG_MAX_POWER, 32'h1);
          write_reg(REG_FORWARD_TRIMS, 32'h8000_7fff);
          write_reg(REG_DIVE_TRIMS, 32'h7fff_8000);
          write_reg(REG_DIVE_OFFSETS, 32'h8000_7fff);
        end
        default: begin
          write_reg(REG_STRAFE_RATIO, $urandom_range(0, 32767));
          write_reg(REG_REVERSE_RATIO, $urandom_range(0, 32767));
          write_reg(REG_MAX_POWER, $urandom_range(0, 3) == 0 ?
                    $urandom_range(0, 32767) : $urandom_range(8000, 20000));
          write_reg(REG_FORWARD_TRIMS, rand_trims());
          write_reg(REG_DIVE_TRIMS, rand_trims());
          write_reg(REG_DIVE_OFFSETS, $urandom_range(0, 1) ? $urandom :
                    {16'($signed($urandom_range(0, 8192)) - 4096),
                     16'($signed($urandom_range(0, 8192)) - 4096)});
        end
      endcase
      idle_gaps = (phase % 4) != 3;
      stall_gaps = (phase % 5) != 4;
      for (int n = 0; n < 160; n++) begin
        logic [1:0] k;
        k = ($urandom_range(0, 9) < 6) ? KIND_MOVE :
            ($urandom_range(0, 3) != 0) ? KIND_YAW : 2'($urandom_range(2, 3));
        send_command(k, rand_q(), rand_q(), rand_q(), rand_q());
        // at n == 80 of phase 5 the sender holds off until everything has come back
        if (n == 80 && phase == 5) begin
          in_valid <= 1'b0;
          while (sb.pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end
    stall_gaps = 1'b0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tcm_pkg.sv
rtl/core/thruster_command_mixer.sv
verif/thruster_command_mixer_tb.sv
